// ----- src/dmac_pkg.sv -----
// shared types and constants for the four channel dma controller
`default_nettype none
package dmac_pkg;
  localparam logic [3:0] CMD_WR_SRC  = 4'd0;
  localparam logic [3:0] CMD_WR_DST  = 4'd1;
  localparam logic [3:0] CMD_WR_LEN  = 4'd2;
  localparam logic [3:0] CMD_WR_CTRL = 4'd3;
  localparam logic [3:0] CMD_RD_LEN  = 4'd4;
  localparam logic [3:0] CMD_RD_CTRL = 4'd5;
  localparam logic [3:0] CMD_WR_FILL = 4'd6;
  localparam logic [3:0] CMD_RD_FILL = 4'd7;
  localparam logic [3:0] CMD_TRIGGER = 4'd8;
  localparam logic [3:0] CMD_TICK    = 4'd9;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_COPY = 2'd2;

  localparam logic [21:0] MAX_LEN_NEW = 22'h200000;
  localparam logic [21:0] MAX_LEN_OLD = 22'h010000;
  localparam logic [4:0]  HIGH_LEN_BITS = 5'h1f;
  localparam int FILL_WORDS = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    OP_NOP, OP_WR_SRC, OP_WR_DST, OP_WR_LEN, OP_WR_CTRL, OP_RD_LEN,
    OP_RD_CTRL, OP_WR_FILL, OP_RD_FILL, OP_TRIGGER, OP_TICK
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        ok;
    logic [1:0]  channel;
    logic [31:0] value;
    logic [31:0] mask;
    logic [2:0]  timing;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] read_data;
    logic [31:0] copy_source;
    logic [31:0] copy_destination;
    logic        unit_is_word;
    logic [1:0]  copy_channel;
    logic        interrupt;
    logic        finished;
  } result_t;
endpackage
`default_nettype wire

// ----- src/dmac_queue.sv -----
// two entry queue between the decode front and the execute back
`default_nettype none
module dmac_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire dmac_pkg::entry_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output dmac_pkg::entry_t     pop_data
);
  import dmac_pkg::*;

  entry_t     store [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = count == 2'(QUEUE_DEPTH);
  assign not_empty = count != 2'd0;
  assign pop_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- src/dmac_engine.sv -----
// channel state, register access and copy sequencing with output register
`default_nettype none
module dmac_engine #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             arch_mode,
  input  wire logic             q_valid,
  input  wire dmac_pkg::entry_t q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output dmac_pkg::result_t     res
);
  import dmac_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [31:0] source_reg [NUM_CHANNELS];
  logic [31:0] destination_reg [NUM_CHANNELS];
  logic [20:0] length_reg [NUM_CHANNELS];
  logic [15:0] control_reg [NUM_CHANNELS];
  logic [31:0] work_source [NUM_CHANNELS];
  logic [31:0] work_destination [NUM_CHANNELS];
  logic [21:0] work_count [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pending;
  logic [31:0] fill_word [FILL_WORDS];

  logic [31:0] source_next [NUM_CHANNELS];
  logic [31:0] destination_next [NUM_CHANNELS];
  logic [20:0] length_next [NUM_CHANNELS];
  logic [15:0] control_next [NUM_CHANNELS];
  logic [31:0] wsrc_next [NUM_CHANNELS];
  logic [31:0] wdst_next [NUM_CHANNELS];
  logic [21:0] wcnt_next [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pending_next;
  logic [31:0] fill_next [FILL_WORDS];
  result_t     res_next;
  logic [NUM_CHANNELS-1:0] enabled;

  function automatic logic [2:0] timing_of(logic [15:0] c, logic am);
    return am ? c[13:11] : {1'b0, c[13:12]};
  endfunction

  function automatic logic [21:0] full_count(logic [20:0] l, logic am);
    if (am) return (l == 21'd0) ? MAX_LEN_NEW : {1'b0, l};
    return (l[15:0] == 16'd0) ? MAX_LEN_OLD : {6'd0, l[15:0]};
  endfunction

  function automatic logic [31:0] step_of(logic [1:0] m, logic [31:0] size);
    unique case (m)
      2'd1: return 32'd0 - size;
      2'd2: return 32'd0;
      default: return size;
    endcase
  endfunction

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    logic [CH_W-1:0] ci;
    logic [CH_W-1:0] pi;
    logic            found;
    logic [15:0]     oldc;
    logic [15:0]     c;
    logic [31:0]     size;
    ci = CH_W'(q_data.channel);
    pi = '0;
    found = 1'b0;
    source_next = source_reg;
    destination_next = destination_reg;
    length_next = length_reg;
    control_next = control_reg;
    wsrc_next = work_source;
    wdst_next = work_destination;
    wcnt_next = work_count;
    pending_next = pending;
    fill_next = fill_word;
    res_next = '0;
    oldc = control_reg[ci];
    c = 16'd0;
    size = 32'd2;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pi = CH_W'(i);
        found = 1'b1;
      end
    end
    unique case (q_data.op)
      OP_WR_SRC: if (q_data.ok) begin
        source_next[ci] = (source_reg[ci] & ~q_data.mask) | (q_data.value & q_data.mask);
      end
      OP_WR_DST: if (q_data.ok) begin
        destination_next[ci] = (destination_reg[ci] & ~q_data.mask)
                             | (q_data.value & q_data.mask);
      end
      OP_WR_LEN: if (q_data.ok) begin
        length_next[ci][15:0] = (length_reg[ci][15:0] & ~q_data.mask[15:0])
                              | (q_data.value[15:0] & q_data.mask[15:0]);
      end
      OP_WR_CTRL: if (q_data.ok) begin
        if (arch_mode) begin
          length_next[ci][20:16] = (length_reg[ci][20:16] & ~q_data.mask[4:0])
                                 | (q_data.value[4:0] & q_data.mask[4:0] & HIGH_LEN_BITS);
        end
        c = (oldc & ~q_data.mask[15:0]) | (q_data.value[15:0] & q_data.mask[15:0]);
        control_next[ci] = c;
        if (!c[15]) begin
          pending_next[ci] = 1'b0;
        end else if (!oldc[15]) begin
          wsrc_next[ci] = source_reg[ci];
          wdst_next[ci] = destination_reg[ci];
          wcnt_next[ci] = full_count(length_next[ci], arch_mode);
          if (timing_of(c, arch_mode) == 3'd0) pending_next[ci] = 1'b1;
        end
      end
      OP_RD_LEN: begin
        res_next.kind = KIND_READ;
        if (q_data.ok) res_next.read_data = {16'd0, length_reg[ci][15:0]};
      end
      OP_RD_CTRL: begin
        res_next.kind = KIND_READ;
        if (q_data.ok) begin
          res_next.read_data = {16'd0, oldc | {11'd0,
                                (arch_mode ? length_reg[ci][20:16] : 5'd0)}};
        end
      end
      OP_WR_FILL: begin
        fill_next[q_data.channel] = (fill_word[q_data.channel] & ~q_data.mask)
                                  | (q_data.value & q_data.mask);
      end
      OP_RD_FILL: begin
        res_next.kind = KIND_READ;
        res_next.read_data = fill_word[q_data.channel];
      end
      OP_TRIGGER: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (control_reg[i][15] && timing_of(control_reg[i], arch_mode) == q_data.timing)
            pending_next[i] = 1'b1;
        end
      end
      OP_TICK: if (found) begin
        c = control_reg[pi];
        size = c[10] ? 32'd4 : 32'd2;
        res_next.kind = KIND_COPY;
        res_next.copy_source = work_source[pi];
        res_next.copy_destination = work_destination[pi];
        res_next.unit_is_word = c[10];
        res_next.copy_channel = 2'(pi);
        wsrc_next[pi] = work_source[pi] + step_of(c[8:7], size);
        wdst_next[pi] = work_destination[pi] + step_of(c[6:5], size);
        if (work_count[pi] > 22'd1) begin
          wcnt_next[pi] = work_count[pi] - 22'd1;
        end else begin
          res_next.interrupt = c[14];
          res_next.finished = 1'b1;
          pending_next[pi] = 1'b0;
          if (c[9] && timing_of(c, arch_mode) != 3'd0) begin
            wcnt_next[pi] = full_count(length_reg[pi], arch_mode);
            if (c[6:5] == 2'd3) wdst_next[pi] = destination_reg[pi];
          end else begin
            control_next[pi] = c & 16'h7fff;
            wcnt_next[pi] = 22'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) enabled[i] = control_reg[i][15];
  end

  always_ff @(posedge clk) begin
    if (q_pop) res <= res_next;
    if (rst) begin
      out_valid <= 1'b0;
      pending <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        source_reg[i] <= '0;
        destination_reg[i] <= '0;
        length_reg[i] <= '0;
        control_reg[i] <= '0;
        work_source[i] <= '0;
        work_destination[i] <= '0;
        work_count[i] <= '0;
      end
      for (int i = 0; i < FILL_WORDS; i++) fill_word[i] <= '0;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
        source_reg <= source_next;
        destination_reg <= destination_next;
        length_reg <= length_next;
        control_reg <= control_next;
        work_source <= wsrc_next;
        work_destination <= wdst_next;
        work_count <= wcnt_next;
        pending <= pending_next;
        fill_word <= fill_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pending_enabled: assert property (@(posedge clk) disable iff (rst)
    (pending & ~enabled) == '0) else $error("pending channel not enabled");
  a_irq_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.interrupt |-> res.finished) else $error("interrupt without finish");
  a_finish_copy: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.finished |-> res.kind == KIND_COPY) else $error("finish on non copy");
  a_reset_clear: assert property (@(posedge clk)
    rst |=> pending == '0 && !out_valid) else $error("reset left state");
endmodule
`default_nettype wire

// ----- src/four_channel_dma_controller_core.sv -----
// four channel dma controller: command decode, queue and execute engine
// a transfer is first written into the queue, then registered in the engine output register
// throughput: one transfer per cycle while the output is not stalled; a trigger may mark several channels pending
// the two entry queue lets the decode side keep accepting while output stalls, until it is full
// reset: synchronous, clears all channel registers, fill words and pending flags
`default_nettype none
module four_channel_dma_controller_core #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  cmd,
  input  wire logic [1:0]  channel,
  input  wire logic [31:0] value,
  input  wire logic [31:0] mask,
  input  wire logic [2:0]  trigger_timing,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [31:0]      read_data,
  output logic [31:0]      copy_source,
  output logic [31:0]      copy_destination,
  output logic             unit_is_word,
  output logic [1:0]       copy_channel,
  output logic             interrupt,
  output logic             finished
);
  import dmac_pkg::*;

  logic    arch_mode;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  entry_t  decoded;
  entry_t  q_data;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      arch_mode <= 1'b1;
    end else if (cfg_we) begin
      arch_mode <= cfg_wdata;
    end
  end

  always_comb begin
    decoded.ok = 32'(channel) < NUM_CHANNELS;
    decoded.channel = channel;
    decoded.value = value;
    decoded.mask = mask;
    decoded.timing = trigger_timing;
    unique case (cmd)
      CMD_WR_SRC:  decoded.op = OP_WR_SRC;
      CMD_WR_DST:  decoded.op = OP_WR_DST;
      CMD_WR_LEN:  decoded.op = OP_WR_LEN;
      CMD_WR_CTRL: decoded.op = OP_WR_CTRL;
      CMD_RD_LEN:  decoded.op = OP_RD_LEN;
      CMD_RD_CTRL: decoded.op = OP_RD_CTRL;
      CMD_WR_FILL: decoded.op = OP_WR_FILL;
      CMD_RD_FILL: decoded.op = OP_RD_FILL;
      CMD_TRIGGER: decoded.op = OP_TRIGGER;
      CMD_TICK:    decoded.op = OP_TICK;
      default:     decoded.op = OP_NOP;
    endcase
  end

  assign in_stall = q_full;

  dmac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_data (decoded),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  dmac_engine #(.NUM_CHANNELS(NUM_CHANNELS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .arch_mode (arch_mode),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign kind = res.kind;
  assign read_data = res.read_data;
  assign copy_source = res.copy_source;
  assign copy_destination = res.copy_destination;
  assign unit_is_word = res.unit_is_word;
  assign copy_channel = res.copy_channel;
  assign interrupt = res.interrupt;
  assign finished = res.finished;
endmodule
`default_nettype wire

// ----- tb/four_channel_dma_controller_core_tb.sv -----
// self-checking testbench for the four channel dma controller core
`default_nettype none
module four_channel_dma_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmac_pkg::*;

  localparam int NCH = 4;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst, cfg_we, cfg_wdata, in_valid, in_stall, out_valid, out_stall;
  logic [3:0] cmd;
  logic [1:0] channel;
  logic [31:0] value, mask;
  logic [2:0] trigger_timing;
  logic [1:0] kind;
  logic [31:0] read_data, copy_source, copy_destination;
  logic unit_is_word, interrupt, finished;
  logic [1:0] copy_channel;

  four_channel_dma_controller_core #(.NUM_CHANNELS(NCH)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .channel(channel),
    .value(value), .mask(mask), .trigger_timing(trigger_timing),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .read_data(read_data),
    .copy_source(copy_source), .copy_destination(copy_destination),
    .unit_is_word(unit_is_word), .copy_channel(copy_channel),
    .interrupt(interrupt), .finished(finished)
  );

  // model state
  logic        m_arch;
  logic [31:0] m_src [NCH];
  logic [31:0] m_dst [NCH];
  logic [20:0] m_len [NCH];
  logic [15:0] m_ctl [NCH];
  logic [31:0] m_wsrc [NCH];
  logic [31:0] m_wdst [NCH];
  logic [21:0] m_wcnt [NCH];
  logic        m_pend [NCH];
  logic [31:0] m_fill [FILL_WORDS];

  result_t expected_results[$];
  int acc_n, cyc, errors, burst_left;
  bit cur_typed;
  result_t cur_exp;

  function automatic logic [31:0] merge(logic [31:0] o, logic [31:0] v, logic [31:0] m);
    return (o & ~m) | (v & m);
  endfunction

  function automatic logic [2:0] timing_of(logic [15:0] c);
    if (m_arch) return c[13:11];
    return {1'b0, c[13:12]};
  endfunction

  function automatic logic [21:0] full_count(int ch);
    if (m_arch) return (m_len[ch] != 0) ? {1'b0, m_len[ch]} : MAX_LEN_NEW;
    return (m_len[ch][15:0] != 0) ? {6'd0, m_len[ch][15:0]} : MAX_LEN_OLD;
  endfunction

  function automatic logic [31:0] addr_step(logic [1:0] md, logic [31:0] sz);
    case (md)
      2'd1: return 32'd0 - sz;
      2'd2: return 32'd0;
      default: return sz;
    endcase
  endfunction

  function automatic result_t dma_predict(logic [3:0] c, logic [1:0] ch, logic [31:0] v,
                                          logic [31:0] m, logic [2:0] t);
    result_t r;
    logic [15:0] o, ct;
    logic [31:0] hm, sz, rv;
    int p;
    bit ok;
    r = '0;
    ok = ch < NCH;
    case (c)
      CMD_WR_SRC: if (ok) m_src[ch] = merge(m_src[ch], v, m);
      CMD_WR_DST: if (ok) m_dst[ch] = merge(m_dst[ch], v, m);
      CMD_WR_LEN: if (ok) m_len[ch] = 21'(merge({11'd0, m_len[ch]}, v, m & 32'hffff));
      CMD_WR_CTRL: if (ok) begin
        o = m_ctl[ch];
        if (m_arch) begin
          hm = (m & 32'h1f) << 16;
          m_len[ch] = 21'(merge({11'd0, m_len[ch]}, (v & 32'h1f) << 16, hm));
        end
        m_ctl[ch] = 16'(merge({16'd0, o}, v, m));
        if (!m_ctl[ch][15]) m_pend[ch] = 0;
        else if (!o[15]) begin
          m_wsrc[ch] = m_src[ch];
          m_wdst[ch] = m_dst[ch];
          m_wcnt[ch] = full_count(ch);
          if (timing_of(m_ctl[ch]) == 0) m_pend[ch] = 1;
        end
      end
      CMD_RD_LEN: begin
        r.kind = KIND_READ;
        if (ok) r.read_data = {16'd0, m_len[ch][15:0]};
      end
      CMD_RD_CTRL: begin
        r.kind = KIND_READ;
        if (ok) begin
          rv = {16'd0, m_ctl[ch]};
          if (m_arch) rv = rv | {27'd0, m_len[ch][20:16]};
          r.read_data = rv;
        end
      end
      CMD_WR_FILL: m_fill[ch] = merge(m_fill[ch], v, m);
      CMD_RD_FILL: begin
        r.kind = KIND_READ;
        r.read_data = m_fill[ch];
      end
      CMD_TRIGGER: for (int i = 0; i < NCH; i++)
        if (m_ctl[i][15] && timing_of(m_ctl[i]) == t) m_pend[i] = 1;
      CMD_TICK: begin
        p = -1;
        for (int i = NCH - 1; i >= 0; i--) if (m_pend[i]) p = i;
        if (p >= 0) begin
          ct = m_ctl[p];
          sz = ct[10] ? 32'd4 : 32'd2;
          r.kind = KIND_COPY;
          r.copy_source = m_wsrc[p];
          r.copy_destination = m_wdst[p];
          r.unit_is_word = ct[10];
          r.copy_channel = p[1:0];
          m_wsrc[p] = m_wsrc[p] + addr_step(ct[8:7], sz);
          m_wdst[p] = m_wdst[p] + addr_step(ct[6:5], sz);
          if (m_wcnt[p] > 22'd1) m_wcnt[p] = m_wcnt[p] - 22'd1;
          else begin
            r.interrupt = ct[14];
            r.finished = 1;
            m_pend[p] = 0;
            if (ct[9] && timing_of(ct) != 0) begin
              m_wcnt[p] = full_count(p);
              if (ct[6:5] == 2'd3) m_wdst[p] = m_dst[p];
            end else begin
              m_ctl[p] = ct & 16'h7fff;
              m_wcnt[p] = 22'd0;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // sampling before the edge updates, so every value seen is the pre-edge one
  always @(posedge clk) begin
    result_t r, e;
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst) begin
      if (cfg_we) m_arch = cfg_wdata;
      if (in_valid && !in_stall) begin
        r = dma_predict(cmd, channel, value, mask, trigger_timing);
        expected_results.push_back(cur_typed ? cur_exp : r);
        acc_n++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no transfer expected");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (kind !== e.kind) begin
            $error("kind exp %0h got %0h", e.kind, kind); errors++;
          end
          if (read_data !== e.read_data) begin
            $error("read_data exp %0h got %0h", e.read_data, read_data); errors++;
          end
          if (copy_source !== e.copy_source) begin
            $error("copy_source exp %0h got %0h", e.copy_source, copy_source); errors++;
          end
          if (copy_destination !== e.copy_destination) begin
            $error("copy_destination exp %0h got %0h", e.copy_destination,
                   copy_destination); errors++;
          end
          if (unit_is_word !== e.unit_is_word) begin
            $error("unit_is_word exp %0h got %0h", e.unit_is_word, unit_is_word); errors++;
          end
          if (copy_channel !== e.copy_channel) begin
            $error("copy_channel exp %0h got %0h", e.copy_channel, copy_channel); errors++;
          end
          if (interrupt !== e.interrupt) begin
            $error("interrupt exp %0h got %0h", e.interrupt, interrupt); errors++;
          end
          if (finished !== e.finished) begin
            $error("finished exp %0h got %0h", e.finished, finished); errors++;
          end
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode, left;
    bit held;
    out_stall = 0;
    mode = 0;
    left = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (!held && cyc > 3000) begin
        held = 1;
        out_stall = 1;
        repeat (120) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(10, 200);
      end
      left--;
      case (mode)
        0: out_stall = 0;
        1: out_stall = ($urandom_range(0, 1) == 0);
        default: out_stall = ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  task automatic send_item(input logic [3:0] c, input logic [1:0] ch, input logic [31:0] v,
                           input logic [31:0] m, input logic [2:0] t,
                           input bit ty = 0, input logic [1:0] k = KIND_ACK,
                           input logic [31:0] rd = 0);
    int target;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      in_valid = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    burst_left--;
    cmd = c;
    channel = ch;
    value = v;
    mask = m;
    trigger_timing = t;
    cur_typed = ty;
    cur_exp = '0;
    cur_exp.kind = k;
    cur_exp.read_data = rd;
    in_valid = 1;
    target = acc_n + 1;
    do @(negedge clk); while (acc_n < target);
  endtask

  task automatic drain_and_set_mode(input logic md);
    in_valid = 0;
    burst_left = 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = md;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_items(input int n);
    int sent, ch, len, nt;
    logic [15:0] ct;
    logic [2:0] tm;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 3) != 0) begin
        ch = $urandom_range(0, NCH - 1);
        if ($urandom_range(0, 1) == 0)
          for (int i = 0; i < ch; i++) begin
            send_item(CMD_WR_CTRL, 2'(i), 0, 32'h8000, 0);
            sent++;
          end
        send_item(CMD_WR_CTRL, 2'(ch), 0, 32'h8000, 0);
        send_item(CMD_WR_SRC, 2'(ch), $urandom, 32'hffffffff, 0);
        send_item(CMD_WR_DST, 2'(ch), $urandom, 32'hffffffff, 0);
        len = $urandom_range(1, 6);
        send_item(CMD_WR_LEN, 2'(ch), {$urandom} & 32'hffff0000 | len,
                  ($urandom_range(0, 7) == 0) ? $urandom | 32'hffff : 32'hffffffff, 0);
        tm = 3'($urandom_range(0, 7));
        ct = 16'($urandom);
        ct[15] = 1;
        ct[4:0] = 0;
        if (m_arch) ct[13:11] = tm; else ct[13:12] = tm[1:0];
        send_item(CMD_WR_CTRL, 2'(ch), {$urandom} & 32'hffff0000 | 32'(ct), 32'hffff, 0);
        sent += 5;
        nt = len + $urandom_range(0, 3);
        for (int i = 0; i < nt; i++) begin
          if ($urandom_range(0, 2) == 0) begin
            send_item(CMD_TRIGGER, 0, $urandom, $urandom, m_arch ? tm : {1'b0, tm[1:0]});
            sent++;
          end
          if ($urandom_range(0, 5) == 0) begin
            send_item(4'($urandom_range(4, 7)), 2'($urandom_range(0, 3)), $urandom,
                      $urandom, 0);
            sent++;
          end
          send_item(CMD_TICK, 2'($urandom), $urandom, $urandom, 3'($urandom));
          sent++;
        end
      end else begin
        send_item(4'($urandom_range(0, 15)), 2'($urandom), $urandom, $urandom,
                  3'($urandom));
        sent++;
      end
    end
  endtask

  typedef struct {
    logic [3:0]  c;
    logic [1:0]  ch;
    logic [31:0] v, m;
    logic [2:0]  t;
    bit          ty;
    logic [1:0]  k;
    logic [31:0] rd;
  } row_t;

  row_t rows[$] = '{
    '{CMD_RD_LEN,  0, 32'h0,        32'h0,        0, 1, KIND_READ, 32'h0},
    '{CMD_RD_CTRL, 3, 32'h0,        32'h0,        0, 1, KIND_READ, 32'h0},
    '{CMD_RD_FILL, 2, 32'h0,        32'h0,        0, 1, KIND_READ, 32'h0},
    '{CMD_TICK,    0, 32'h0,        32'h0,        0, 1, KIND_ACK,  32'h0},
    '{CMD_WR_FILL, 1, 32'hffffffff, 32'hffffffff, 0, 1, KIND_ACK,  32'h0},
    '{CMD_RD_FILL, 1, 32'h0,        32'h0,        0, 1, KIND_READ, 32'hffffffff},
    '{CMD_WR_FILL, 1, 32'h0,        32'h0000ffff, 7, 1, KIND_ACK,  32'h0},
    '{CMD_RD_FILL, 1, 32'h0,        32'h0,        0, 1, KIND_READ, 32'hffff0000},
    '{CMD_WR_SRC,  0, 32'hffffffff, 32'hffffffff, 0, 1, KIND_ACK,  32'h0},
    '{CMD_WR_DST,  0, 32'h00001000, 32'hffffffff, 0, 1, KIND_ACK,  32'h0},
    '{CMD_WR_LEN,  0, 32'hffff0002, 32'hffffffff, 0, 1, KIND_ACK,  32'h0},
    '{CMD_RD_LEN,  0, 32'h0,        32'h0,        0, 1, KIND_READ, 32'h2},
    '{CMD_WR_CTRL, 0, 32'h00008460, 32'h0000ffff, 0, 0, KIND_ACK,  32'h0},
    '{CMD_TICK,    0, 32'h0,        32'h0,        0, 0, KIND_ACK,  32'h0},
    '{CMD_TICK,    0, 32'h0,        32'h0,        0, 0, KIND_ACK,  32'h0},
    '{CMD_TICK,    0, 32'h0,        32'h0,        0, 1, KIND_ACK,  32'h0},
    '{CMD_RD_CTRL, 0, 32'h0,        32'h0,        0, 0, KIND_ACK,  32'h0},
    '{4'd15,       2, 32'hffffffff, 32'hffffffff, 7, 1, KIND_ACK,  32'h0},
    '{4'd12,       1, 32'h0,        32'h0,        0, 1, KIND_ACK,  32'h0},
    '{CMD_WR_CTRL, 1, 32'h0000801f, 32'hffffffff, 0, 0, KIND_ACK,  32'h0},
    '{CMD_RD_CTRL, 1, 32'h0,        32'h0,        0, 0, KIND_ACK,  32'h0},
    '{CMD_WR_CTRL, 1, 32'h0,        32'h00008000, 0, 0, KIND_ACK,  32'h0},
    '{CMD_WR_LEN,  2, 32'h00000001, 32'h0000ffff, 0, 0, KIND_ACK,  32'h0},
    '{CMD_WR_CTRL, 2, 32'h0000ca00, 32'h0000ffff, 0, 0, KIND_ACK,  32'h0},
    '{CMD_TRIGGER, 0, 32'h0,        32'h0,        1, 0, KIND_ACK,  32'h0},
    '{CMD_TICK,    0, 32'h0,        32'h0,        0, 0, KIND_ACK,  32'h0},
    '{CMD_TICK,    0, 32'h0,        32'h0,        0, 1, KIND_ACK,  32'h0}
  };

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    cmd = 0;
    channel = 0;
    value = 0;
    mask = 0;
    trigger_timing = 0;
    cur_typed = 0;
    cur_exp = '0;
    acc_n = 0;
    cyc = 0;
    errors = 0;
    burst_left = 0;
    m_arch = 1;
    for (int i = 0; i < NCH; i++) begin
      m_src[i] = 0; m_dst[i] = 0; m_len[i] = 0; m_ctl[i] = 0;
      m_wsrc[i] = 0; m_wdst[i] = 0; m_wcnt[i] = 0; m_pend[i] = 0;
    end
    for (int i = 0; i < FILL_WORDS; i++) m_fill[i] = 0;
    repeat (2) @(negedge clk);
    rst = 0;
    foreach (rows[i])
      send_item(rows[i].c, rows[i].ch, rows[i].v, rows[i].m, rows[i].t,
                rows[i].ty, rows[i].k, rows[i].rd);
    drain_and_set_mode(0);
    random_items(540);
    drain_and_set_mode(1);
    random_items(540);
    drain_and_set_mode(0);
    random_items(540);
    in_valid = 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- four_channel_dma_controller_core.f -----
src/dmac_pkg.sv
src/dmac_queue.sv
src/dmac_engine.sv
src/four_channel_dma_controller_core.sv
tb/four_channel_dma_controller_core_tb.sv
